[rtl/linear_interp_resampler_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LIRS_ASSERT_IMPLY(lbl_, ck_, rn_, ante_, cons_) \
  lbl_: assert property (@(posedge ck_) disable iff (!rn_) (ante_) |-> (cons_)) \
    else $error("lirs assertion failed");
// next-cycle implication
`define LIRS_ASSERT_NEXT(lbl_, ck_, rn_, ante_, cons_) \
  lbl_: assert property (@(posedge ck_) disable iff (!rn_) (ante_) |=> (cons_)) \
    else $error("lirs assertion failed");
`else
`define LIRS_ASSERT_IMPLY(lbl_, ck_, rn_, ante_, cons_)
`define LIRS_ASSERT_NEXT(lbl_, ck_, rn_, ante_, cons_)
`endif

`endif

[rtl/lirs_pkg.sv]
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared widths, register indexes and state types of the resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int RATE_W    = 18;
  localparam int SAMP_W    = 16;
  localparam int RES_W     = 19;
  localparam int STEP_W    = 5;
  localparam int REG_IDX_W = 1;
  localparam int TUSER_W   = 2;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd8000;

  localparam logic [REG_IDX_W-1:0] REG_SRC_RATE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DST_RATE = 1'd1;

  // out_tuser bit positions
  localparam int TU_EOS = 0;
  localparam int TU_OVF = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MOD,
    ST_PLAN,
    ST_W1_CALC,
    ST_W1_WAIT,
    ST_W1_PUT,
    ST_W2_PUT,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    IP_IDLE,
    IP_MUL,
    IP_ABS,
    IP_DIV
  } ip_state_t;

endpackage

[rtl/lirs_mod.sv]
// ----------------------------------------------------------------------------
// lirs_mod
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lirs_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lirs_pkg::RATE_W-1:0]   dividend,
  input  logic [lirs_pkg::RATE_W-1:0]   divisor,
  output logic                          done,
  output logic [lirs_pkg::RATE_W-1:0]   rem
);

  localparam logic [lirs_pkg::STEP_W-1:0] LAST_STEP =
    lirs_pkg::STEP_W'(lirs_pkg::RATE_W - 1);

  logic                          busy_r;
  logic                          done_r;
  logic [lirs_pkg::STEP_W-1:0]   cnt_r;
  logic [lirs_pkg::RATE_W-1:0]   dsr_r;
  logic [lirs_pkg::RATE_W-1:0]   rem_r;
  logic [lirs_pkg::RATE_W:0]     trial;
  logic [lirs_pkg::RATE_W:0]     trial_sub;
  logic                          fits;

  always_comb begin
    trial     = {rem_r, dsr_r[lirs_pkg::RATE_W-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      dsr_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      dsr_r <= {dsr_r[lirs_pkg::RATE_W-2:0], 1'b0};
      rem_r <= fits ? trial_sub[lirs_pkg::RATE_W-1:0] : trial[lirs_pkg::RATE_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[rtl/lirs_interp.sv]
// ----------------------------------------------------------------------------
// lirs_interp
// Bit-serial interpolation: a*(dst-ri) + b*ri, then divide by dst.
// ----------------------------------------------------------------------------
module lirs_interp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [lirs_pkg::SAMP_W-1:0] a,
  input  logic signed [lirs_pkg::SAMP_W-1:0] b,
  input  logic [lirs_pkg::RATE_W-1:0]   ri,
  input  logic [lirs_pkg::RATE_W-1:0]   dst,
  output logic                          done,
  output logic [lirs_pkg::SAMP_W-1:0]   q
);

  localparam int HI_W   = lirs_pkg::RATE_W + 1;
  localparam int NUM_W  = HI_W + lirs_pkg::RATE_W;
  localparam logic [lirs_pkg::STEP_W-1:0] MUL_LAST =
    lirs_pkg::STEP_W'(lirs_pkg::RATE_W - 1);
  localparam logic [lirs_pkg::STEP_W-1:0] DIV_LAST =
    lirs_pkg::STEP_W'(lirs_pkg::SAMP_W - 1);

  lirs_pkg::ip_state_t st_r, st_nxt;

  logic                          done_r;
  logic [lirs_pkg::STEP_W-1:0]   cnt_r;
  logic [lirs_pkg::RATE_W-1:0]   ri_sr;
  logic [lirs_pkg::RATE_W-1:0]   w_sr;
  logic signed [HI_W-1:0]        hi_r;
  logic [lirs_pkg::RATE_W-1:0]   lo_r;
  logic                          neg_r;
  logic [lirs_pkg::RATE_W-1:0]   rem_r;
  logic [lirs_pkg::SAMP_W-1:0]   qs_r;

  logic signed [HI_W-1:0]        add_a;
  logic signed [HI_W-1:0]        add_b;
  logic signed [HI_W-1:0]        hi_sum;
  logic [NUM_W-1:0]              num_u;
  logic [NUM_W-1:0]              mag;
  logic [lirs_pkg::RATE_W:0]     trial;
  logic [lirs_pkg::RATE_W:0]     trial_sub;
  logic                          fits;
  logic                          mul_last;
  logic                          div_last;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lirs_pkg::IP_IDLE: if (start) st_nxt = lirs_pkg::IP_MUL;
      lirs_pkg::IP_MUL:  if (cnt_r == MUL_LAST) st_nxt = lirs_pkg::IP_ABS;
      lirs_pkg::IP_ABS:  st_nxt = lirs_pkg::IP_DIV;
      lirs_pkg::IP_DIV:  if (cnt_r == DIV_LAST) st_nxt = lirs_pkg::IP_IDLE;
      default:           st_nxt = lirs_pkg::IP_IDLE;
    endcase
  end

  // step controls
  always_comb begin
    mul_last = (st_r == lirs_pkg::IP_MUL) && (cnt_r == MUL_LAST);
    div_last = (st_r == lirs_pkg::IP_DIV) && (cnt_r == DIV_LAST);
  end

  always_comb begin
    add_a     = w_sr[0]  ? {{(HI_W-lirs_pkg::SAMP_W){a[lirs_pkg::SAMP_W-1]}}, a} : '0;
    add_b     = ri_sr[0] ? {{(HI_W-lirs_pkg::SAMP_W){b[lirs_pkg::SAMP_W-1]}}, b} : '0;
    hi_sum    = hi_r + add_a + add_b;
    num_u     = {hi_r, lo_r};
    mag       = num_u[NUM_W-1] ? ({NUM_W{1'b0}} - num_u) : num_u;
    trial     = {rem_r, qs_r[lirs_pkg::SAMP_W-1]};
    trial_sub = trial - {1'b0, dst};
    fits      = trial >= {1'b0, dst};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= lirs_pkg::IP_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= div_last;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      lirs_pkg::IP_IDLE: begin
        if (start) begin
          cnt_r <= '0;
          ri_sr <= ri;
          w_sr  <= dst - ri;
          hi_r  <= '0;
        end
      end
      lirs_pkg::IP_MUL: begin
        // shift one product bit out per cycle
        cnt_r <= mul_last ? '0 : cnt_r + 1'b1;
        ri_sr <= ri_sr >> 1;
        w_sr  <= w_sr >> 1;
        lo_r  <= {hi_sum[0], lo_r[lirs_pkg::RATE_W-1:1]};
        hi_r  <= hi_sum >>> 1;
      end
      lirs_pkg::IP_ABS: begin
        neg_r <= num_u[NUM_W-1];
        rem_r <= mag[lirs_pkg::RATE_W+lirs_pkg::SAMP_W-1:lirs_pkg::SAMP_W];
        qs_r  <= mag[lirs_pkg::SAMP_W-1:0];
      end
      lirs_pkg::IP_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= fits ? trial_sub[lirs_pkg::RATE_W-1:0] : trial[lirs_pkg::RATE_W-1:0];
        qs_r  <= {qs_r[lirs_pkg::SAMP_W-2:0], fits};
      end
      default: cnt_r <= '0;
    endcase
  end

  assign done = done_r;
  assign q    = neg_r ? ({lirs_pkg::SAMP_W{1'b0}} - qs_r) : qs_r;

endmodule

[rtl/linear_interp_resampler_top.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Linear interpolation sample rate converter, src_rate to dst_rate.
// ----------------------------------------------------------------------------
// Source samples enter on the in_ stream, one item each; in_tlast marks the
// final sample of a stream. Each item yields zero or more interpolated
// samples on the out_ stream; out_tlast marks the last one caused by that
// item, out_tuser flags the end of the stream and dropped outputs.
// The user must write src_rate and dst_rate on the cfg_ port only while the
// block is idle; the block does not enforce this. One item is processed at
// a time. Per item the control steps through accept, setup, plan and finish,
// plus the serial remainder unit when a window is open, plus the
// interpolator per interpolated result (18-step bit-serial multiply and
// 16-step bit-serial divide in lirs_interp) and an output step per
// end-of-stream result, each extended while the receiver stalls. The first
// result is registered after setup, the remainder unit, plan and the
// interpolator when a window is open, else after setup and plan. Results
// wait in a single output register; a stalled receiver holds the block in
// its output step, and the next item is accepted after the finish step.
// Reset (rst_n low, synchronous) sets both rates to 8000 and starts a new
// stream; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_top_assert.svh"

module linear_interp_resampler_top #(
  parameter int MAX_PER_WINDOW = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [15:0] in_sample
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lirs_pkg::SAMP_W-1:0]         in_tdata,
  input  logic                                in_tlast,
  // out_tdata: [15:0] out_sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lirs_pkg::SAMP_W-1:0]         out_tdata,
  output logic                                out_tlast,
  // out_tuser: [0] end_of_stream, [1] overflow
  output logic [lirs_pkg::TUSER_W-1:0]        out_tuser,
  input  logic                                cfg_we,
  input  logic [lirs_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  logic [lirs_pkg::RATE_W-1:0]         cfg_wdata
);

  localparam int K_W  = $clog2(MAX_PER_WINDOW + 1);
  localparam int MX_W = lirs_pkg::RATE_W + K_W;
  localparam int CW   = MX_W + 2;
  localparam int RW   = lirs_pkg::RATE_W;
  localparam int SW   = lirs_pkg::SAMP_W;
  localparam int RES  = lirs_pkg::RES_W;

  lirs_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]   src_r, dst_r;
  logic [RW-1:0]   src_e, dst_e;
  logic [SW-1:0]   prev_r;
  logic            have_prev_r;
  logic [RES-1:0]  res_r;

  logic [SW-1:0]   cur_r;
  logic            last_r;
  logic [MX_W-1:0] mx_r;
  logic [RES-1:0]  ri_r;
  logic [RES-1:0]  r2_r;
  logic [K_W-1:0]  k_r;
  logic            w1_on_r, w2_on_r, ovf1_r, ovf2_r;
  logic [SW-1:0]   q_r;

  logic            out_valid_r;
  logic [SW-1:0]   out_data_r;
  logic            out_last_r;
  logic            out_eos_r;
  logic            out_ovf_r;

  logic            in_acc;
  logic            slot_free;
  logic            load_out;
  logic            w1_cond;
  logic            w2_cond;
  logic            w1_final;
  logic            w2_final;
  logic            k_end;
  logic            mod_start;
  logic            mod_done;
  logic [RW-1:0]   mod_rem;
  logic            ip_start;
  logic            ip_done;
  logic [SW-1:0]   ip_q;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= lirs_pkg::RATE_RESET;
      dst_r <= lirs_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lirs_pkg::REG_SRC_RATE: src_r <= cfg_wdata;
        lirs_pkg::REG_DST_RATE: dst_r <= cfg_wdata;
      endcase
    end
  end

  // a zero rate counts as one
  assign src_e = (src_r == '0) ? RW'(1) : src_r;
  assign dst_e = (dst_r == '0) ? RW'(1) : dst_r;

  always_comb begin
    in_acc    = in_tvalid && in_tready;
    slot_free = !out_valid_r || out_tready;
    w1_cond   = have_prev_r && (res_r < RES'(dst_e));
    w2_cond   = last_r && (CW'(r2_r) + CW'(src_e) <= CW'(dst_e));
    k_end     = (k_r == K_W'(MAX_PER_WINDOW - 1));
    w1_final  = (CW'(ri_r) + CW'(src_e) >= CW'(dst_e)) || k_end;
    w2_final  = (CW'(ri_r) + CW'(src_e) + CW'(src_e) > CW'(dst_e)) || k_end;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lirs_pkg::ST_IDLE:    if (in_acc) state_nxt = lirs_pkg::ST_SETUP;
      lirs_pkg::ST_SETUP:   state_nxt = w1_cond ? lirs_pkg::ST_MOD : lirs_pkg::ST_PLAN;
      lirs_pkg::ST_MOD:     if (mod_done) state_nxt = lirs_pkg::ST_PLAN;
      lirs_pkg::ST_PLAN: begin
        if (w1_on_r)      state_nxt = lirs_pkg::ST_W1_CALC;
        else if (w2_cond) state_nxt = lirs_pkg::ST_W2_PUT;
        else              state_nxt = lirs_pkg::ST_FIN;
      end
      lirs_pkg::ST_W1_CALC: state_nxt = lirs_pkg::ST_W1_WAIT;
      lirs_pkg::ST_W1_WAIT: if (ip_done) state_nxt = lirs_pkg::ST_W1_PUT;
      lirs_pkg::ST_W1_PUT: begin
        if (slot_free) begin
          if (!w1_final)    state_nxt = lirs_pkg::ST_W1_CALC;
          else if (w2_on_r) state_nxt = lirs_pkg::ST_W2_PUT;
          else              state_nxt = lirs_pkg::ST_FIN;
        end
      end
      lirs_pkg::ST_W2_PUT:  if (slot_free && w2_final) state_nxt = lirs_pkg::ST_FIN;
      lirs_pkg::ST_FIN:     state_nxt = lirs_pkg::ST_IDLE;
      default:              state_nxt = lirs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = (state_r == lirs_pkg::ST_IDLE);
    mod_start = (state_r == lirs_pkg::ST_SETUP) && w1_cond;
    ip_start  = (state_r == lirs_pkg::ST_W1_CALC);
    load_out  = ((state_r == lirs_pkg::ST_W1_PUT) || (state_r == lirs_pkg::ST_W2_PUT)) &&
                slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lirs_pkg::ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      res_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == lirs_pkg::ST_FIN) begin
        // end of stream: back to a fresh start
        if (last_r) begin
          prev_r      <= '0;
          have_prev_r <= 1'b0;
          res_r       <= '0;
        end else begin
          prev_r      <= cur_r;
          have_prev_r <= 1'b1;
          res_r       <= r2_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      lirs_pkg::ST_IDLE: begin
        if (in_acc) begin
          cur_r  <= in_tdata;
          last_r <= in_tlast;
        end
      end
      lirs_pkg::ST_SETUP: begin
        mx_r    <= MX_W'(MAX_PER_WINDOW) * MX_W'(src_e);
        ri_r    <= have_prev_r ? res_r : '0;
        w1_on_r <= w1_cond;
        if (!w1_cond) begin
          r2_r <= have_prev_r ? (res_r - RES'(dst_e)) : '0;
        end
      end
      lirs_pkg::ST_MOD: begin
        // step past the window edge: src minus the leftover of dst - r
        if (mod_done) begin
          r2_r <= (mod_rem == '0) ? '0 : RES'(src_e - mod_rem);
        end
      end
      lirs_pkg::ST_PLAN: begin
        ovf1_r  <= (CW'(ri_r) + CW'(mx_r)) < CW'(dst_e);
        ovf2_r  <= (CW'(r2_r) + CW'(mx_r) + CW'(src_e)) <= CW'(dst_e);
        w2_on_r <= w2_cond;
        k_r     <= '0;
        if (!w1_on_r) begin
          ri_r <= r2_r;
        end
      end
      lirs_pkg::ST_W1_WAIT: begin
        if (ip_done) begin
          q_r <= ip_q;
        end
      end
      lirs_pkg::ST_W1_PUT: begin
        if (slot_free) begin
          if (w1_final) begin
            ri_r <= r2_r;
            k_r  <= '0;
          end else begin
            ri_r <= ri_r + RES'(src_e);
            k_r  <= k_r + 1'b1;
          end
        end
      end
      lirs_pkg::ST_W2_PUT: begin
        if (slot_free) begin
          ri_r <= ri_r + RES'(src_e);
          k_r  <= k_r + 1'b1;
        end
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == lirs_pkg::ST_W1_PUT) begin
        out_data_r <= q_r;
        out_last_r <= w1_final && !w2_on_r;
        out_eos_r  <= w1_final && !w2_on_r && last_r;
        out_ovf_r  <= ovf1_r;
      end else begin
        out_data_r <= cur_r;
        out_last_r <= w2_final;
        out_eos_r  <= w2_final;
        out_ovf_r  <= ovf2_r;
      end
    end
  end

  assign out_tvalid                  = out_valid_r;
  assign out_tdata                   = out_data_r;
  assign out_tlast                   = out_last_r;
  assign out_tuser[lirs_pkg::TU_EOS] = out_eos_r;
  assign out_tuser[lirs_pkg::TU_OVF] = out_ovf_r;

  lirs_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (dst_e - res_r[RW-1:0]),
    .divisor  (src_e),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lirs_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ip_start),
    .a     (prev_r),
    .b     (cur_r),
    .ri    (ri_r[RW-1:0]),
    .dst   (dst_e),
    .done  (ip_done),
    .q     (ip_q)
  );

  `LIRS_ASSERT_IMPLY(a_k_bound, clk, rst_n, (state_r == lirs_pkg::ST_W1_PUT) || (state_r == lirs_pkg::ST_W2_PUT), k_r < K_W'(MAX_PER_WINDOW))
  `LIRS_ASSERT_IMPLY(a_ri_in_window, clk, rst_n, state_r == lirs_pkg::ST_W1_CALC, ri_r < RES'(dst_e))
  `LIRS_ASSERT_IMPLY(a_residue_below_src, clk, rst_n, (state_r == lirs_pkg::ST_PLAN) && w1_on_r, r2_r < RES'(src_e))
  `LIRS_ASSERT_IMPLY(a_ip_done_waited, clk, rst_n, ip_done, state_r == lirs_pkg::ST_W1_WAIT)
  `LIRS_ASSERT_IMPLY(a_eos_ends_run, clk, rst_n, out_valid_r && out_eos_r, out_last_r)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for linear_interp_resampler_top
// Drives source samples as streams of random length through several rate
// settings, predicts every interpolated sample, run marker, end-of-stream
// flag and overflow flag, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN    = 32;
  localparam int SETTLE_CYC = 120;
  // Timeout for 385 items of up to 64 results each, plus receiver stalls
  localparam int LIMIT      = 8_000_000;
  localparam int N_PHASES   = 10;

  typedef struct packed {
    logic [lirs_pkg::SAMP_W-1:0] smp;
    logic                        last;
  } src_item_t;

  typedef struct packed {
    logic [lirs_pkg::SAMP_W-1:0] smp;
    logic                        run_end;
    logic                        stream_end;
    logic                        dropped;
  } interp_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lirs_pkg::SAMP_W-1:0]    in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lirs_pkg::SAMP_W-1:0]    out_tdata;
  logic                           out_tlast;
  logic [lirs_pkg::TUSER_W-1:0]   out_tuser;
  logic                           cfg_we = 1'b0;
  logic [lirs_pkg::REG_IDX_W-1:0] cfg_addr = '0;
  logic [lirs_pkg::RATE_W-1:0]    cfg_wdata = '0;

  // predictor state
  logic [lirs_pkg::RATE_W-1:0]        rate_src = lirs_pkg::RATE_RESET;
  logic [lirs_pkg::RATE_W-1:0]        rate_dst = lirs_pkg::RATE_RESET;
  logic signed [lirs_pkg::SAMP_W-1:0] prev_val = '0;
  logic                               have_prev = 1'b0;
  logic [18:0]                        resid = '0;

  src_item_t src_q[$];
  interp_t   interp_q[$];

  int n_in = 0, n_out = 0, n_ovf = 0, n_err = 0, n_rates = 0, cycles = 0;
  int burst_left = 1, gap_left = 0, stall_mode = 0, stall_left = 0;
  logic [lirs_pkg::SAMP_W-1:0] walk_val = '0;

  int unsigned phase_src [N_PHASES] =
    '{44100, 48000, 8000, 196000, 0, 11025, 1, 262143, 196000, 22050};
  int unsigned phase_dst [N_PHASES] =
    '{48000, 44100, 22050, 8000, 0, 196000, 196000, 3, 196000, 44100};
  int phase_items [N_PHASES] = '{65, 65, 40, 40, 25, 40, 5, 25, 30, 30};
  bit phase_close [N_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 1};

  linear_interp_resampler_top #(.MAX_PER_WINDOW(MAX_RUN)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Interpolate one window; the phase still advances past dropped outputs.
  function automatic int put_window(longint a, longint b, longint unsigned r0,
                                    longint unsigned cnt, longint unsigned src,
                                    longint unsigned dst);
    longint unsigned n, ri;
    longint num;
    logic ovf;
    interp_t e;
    n = cnt;
    ovf = 1'b0;
    if (n > MAX_RUN) begin
      n = MAX_RUN;
      ovf = 1'b1;
    end
    for (int i = 0; i < int'(n); i++) begin
      ri = r0 + longint'(i) * src;
      num = a * longint'(dst - ri) + b * longint'(ri);
      e.smp = lirs_pkg::SAMP_W'(num / longint'(dst));
      e.run_end = 1'b0;
      e.stream_end = 1'b0;
      e.dropped = ovf;
      interp_q.push_back(e);
    end
    return int'(n);
  endfunction

  task automatic resample_step(logic [lirs_pkg::SAMP_W-1:0] smp, logic last);
    longint unsigned src, dst, r, cnt;
    longint cur;
    int n;
    interp_t tail;
    src = (rate_src == 0) ? 64'd1 : longint'(rate_src);
    dst = (rate_dst == 0) ? 64'd1 : longint'(rate_dst);
    cur = longint'($signed(smp));
    r = longint'(resid);
    n = 0;
    if (have_prev) begin
      cnt = (r < dst) ? (dst - r - 1) / src + 1 : 64'd0;
      n += put_window(longint'(prev_val), cur, r, cnt, src, dst);
      r = r + cnt * src - dst;
    end else begin
      r = 0;
    end
    if (last) begin
      // final window: the sample stands for itself up to the end clamp
      cnt = (r + src <= dst) ? (dst - src - r) / src + 1 : 64'd0;
      n += put_window(cur, cur, r, cnt, src, dst);
      prev_val = '0;
      have_prev = 1'b0;
      resid = '0;
    end else begin
      prev_val = smp;
      have_prev = 1'b1;
      resid = r[18:0];
    end
    if (n > 0) begin
      tail = interp_q.pop_back();
      tail.run_end = 1'b1;
      tail.stream_end = last;
      interp_q.push_back(tail);
    end
  endtask

  task automatic report(string field, longint got, longint want);
    if (n_err < 40)
      $display("mismatch on result %0d (%s): got %0d, expected %0d", n_out, field, got, want);
    n_err++;
  endtask

  // Sender: bursts of random length, random gaps, some stretches with no gap.
  always @(posedge clk) begin : drv
    src_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        resample_step(in_tdata, in_tlast);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || src_q.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          it = src_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.smp;
          in_tlast <= it.last;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: check each accepted item, then pick the next stall.
  always @(posedge clk) begin : mon
    interp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (interp_q.size() == 0) begin
          report("unexpected", longint'($signed(out_tdata)), longint'(0));
        end else begin
          e = interp_q.pop_front();
          if (out_tdata !== e.smp)
            report("sample", longint'($signed(out_tdata)), longint'($signed(e.smp)));
          if (out_tlast !== e.run_end)
            report("tlast", longint'(out_tlast), longint'(e.run_end));
          if (out_tuser[lirs_pkg::TU_EOS] !== e.stream_end)
            report("end of stream", longint'(out_tuser[lirs_pkg::TU_EOS]),
                   longint'(e.stream_end));
          if (out_tuser[lirs_pkg::TU_OVF] !== e.dropped)
            report("overflow", longint'(out_tuser[lirs_pkg::TU_OVF]), longint'(e.dropped));
          if (e.dropped) n_ovf++;
        end
        n_out++;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, interp_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic [lirs_pkg::SAMP_W-1:0] pick_sample();
    int k;
    k = $urandom_range(0, 19);
    if (k < 10) begin
      walk_val = lirs_pkg::SAMP_W'($urandom);
    end else if (k < 13) begin
      case ($urandom_range(0, 3))
        0:       walk_val = 16'h8000;
        1:       walk_val = 16'h7fff;
        2:       walk_val = 16'h0000;
        default: walk_val = 16'hffff;
      endcase
    end else begin
      walk_val = walk_val + lirs_pkg::SAMP_W'($urandom_range(0, 2000) - 1000);
    end
    return walk_val;
  endfunction

  function automatic int pick_len();
    int k;
    k = $urandom_range(0, 15);
    if (k < 2) return 1;
    if (k == 15) return $urandom_range(40, 80);
    return $urandom_range(2, 24);
  endfunction

  task automatic push_src(logic [lirs_pkg::SAMP_W-1:0] smp, logic last);
    src_item_t it;
    it.smp = smp;
    it.last = last;
    src_q.push_back(it);
  endtask

  // Leave a stream open at the end unless asked to close it.
  task automatic queue_streams(int n_items, bit close_end);
    int left;
    left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) left = pick_len();
      left--;
      push_src(pick_sample(), (left == 0) || (close_end && i == n_items - 1));
      if (close_end && i == n_items - 1) left = 0;
    end
  endtask

  // Hold until the block has drained, plus time for items with no result.
  task automatic wait_idle();
    do @(negedge clk); while (src_q.size() != 0 || in_tvalid || interp_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_rate(logic [lirs_pkg::REG_IDX_W-1:0] idx,
                            logic [lirs_pkg::RATE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == lirs_pkg::REG_SRC_RATE) rate_src = val;
    else rate_dst = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_rates(logic [lirs_pkg::RATE_W-1:0] src, logic [lirs_pkg::RATE_W-1:0] dst);
    wait_idle();
    write_rate(lirs_pkg::REG_SRC_RATE, src);
    write_rate(lirs_pkg::REG_DST_RATE, dst);
    n_rates++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // equal rates after reset: single-sample stream, then extremes
    push_src(16'sd32767, 1'b1);
    push_src(16'h8000, 1'b0);
    push_src(16'h7fff, 1'b0);
    push_src(16'h0000, 1'b0);
    push_src(16'hffff, 1'b1);
    // upsample by three across full-scale steps
    set_rates(18'd1, 18'd3);
    push_src(16'h8000, 1'b0);
    push_src(16'h7fff, 1'b0);
    push_src(16'h7fff, 1'b0);
    push_src(16'h8000, 1'b1);
    // downsample by three: final items that yield nothing
    set_rates(18'd3, 18'd1);
    push_src(16'd100, 1'b1);
    push_src(16'd5, 1'b0);
    push_src(16'd6, 1'b0);
    push_src(16'd7, 1'b1);
    // zero rates act as one
    set_rates(18'd0, 18'd0);
    push_src(16'd1234, 1'b0);
    push_src(-16'sd4321, 1'b1);
    // window excess on both windows of a closing item
    set_rates(18'd1, 18'd40);
    push_src(16'h8000, 1'b0);
    push_src(16'h7fff, 1'b1);
    // rate change with a stream still open
    push_src(-16'sd20000, 1'b0);
    set_rates(18'd5, 18'd7);
    push_src(16'sd30000, 1'b0);
    push_src(-16'sd30000, 1'b1);

    for (int p = 0; p < N_PHASES; p++) begin
      set_rates(lirs_pkg::RATE_W'(phase_src[p]), lirs_pkg::RATE_W'(phase_dst[p]));
      queue_streams(phase_items[p], phase_close[p]);
    end
    wait_idle();

    $display("summary: %0d source samples in, %0d results checked, %0d of them overflowed",
             n_in, n_out, n_ovf);
    $display("summary: %0d rate settings, from zero and 1 Hz up to 262143 Hz", n_rates);
    if (n_err == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[linear_interp_resampler_top.f]
+incdir+rtl
rtl/lirs_pkg.sv
rtl/lirs_mod.sv
rtl/lirs_interp.sv
rtl/linear_interp_resampler_top.sv
tb/tb.sv
